@@ sv/start_code_frame_packetizer_defines.svh @@
// ----------------------------------------------------------------------------
// start_code_frame_packetizer_defines
// Assertion macros used by the start code packetizer datapath.
// ----------------------------------------------------------------------------
`ifndef START_CODE_FRAME_PACKETIZER_DEFINES_SVH
`define START_CODE_FRAME_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfp: next-cycle check failed");

`endif

@@ sv/scfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants of the start code frame packetizer.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned LEN_W            = 11;
  localparam int unsigned HELD_W           = 6;
  localparam int unsigned FRAME_W          = 32;
  localparam int unsigned PACKET_W         = 16;
  localparam int unsigned OUT_TDATA_W      = 72;
  localparam int unsigned ZERO_RUN_MAX_DEF = 32;

  localparam logic [LEN_W-1:0]   LIMIT_RESET = LEN_W'(1400);
  localparam logic [HELD_W-1:0]  START_ZEROS = HELD_W'(3);
  localparam logic [BYTE_W-1:0]  START_BYTE  = BYTE_W'(1);
  localparam logic [FRAME_W-1:0] FRAME_RESET = '1;
  localparam logic [FRAME_W-1:0] FRAME_WRAP  = 32'h7FFF_FFFF;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_CLOSE   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    EMIT_CLOSE = 2'd0,
    EMIT_ZERO  = 2'd1,
    EMIT_BYTE  = 2'd2
  } emit_e;

  // controller -> datapath
  typedef struct packed {
    logic  load;       // input transaction taken
    logic  emit;       // write one result into the output register
    emit_e emit_sel;
    logic  finish;     // close caused by a start code
    logic  last;       // final result of the current input byte
    logic  new_frame;  // advance frame, restart packet numbering
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_zero;
    logic start_code;
    logic run_full;
    logic fill_zero;
    logic over_limit;
    logic held_zero;
    logic held_one;
    logic extra;
    logic out_free;
  } status_t;

endpackage

@@ sv/start_code_frame_packetizer.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted byte that ends a start code first closes the packet (an empty packet
//   is skipped); every released byte then passes a limit check, which may write a close marker,
//   and then writes its held zeros and, if nonzero, the byte itself as payload results.
// A zero byte that is only held ends there; no new byte is taken until every result of the
//   last one is written, and output stalls hold the sequence.
// Reset: rst_ni low clears all counters, frame number to -1, limit to 1400.
// ----------------------------------------------------------------------------
// start_code_frame_packetizer
// Cuts an encoded byte stream into packets at start codes and a payload limit.
// ----------------------------------------------------------------------------
module start_code_frame_packetizer #(
  parameter int unsigned ZERO_RUN_MAX = scfp_pkg::ZERO_RUN_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scfp_pkg::LEN_W-1:0]       cfg_wdata_i,    // payload_limit
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [scfp_pkg::BYTE_W-1:0]      s_axis_tdata,   // stream_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // payload_byte, frame_number, packet_number, first_in_frame,
  // frame_finish, packet_length, zero pad
  output logic [scfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,   // item_kind
  output logic                             m_axis_tlast    // last_of_run
);
  import scfp_pkg::*;

  cmd_t    cmd;
  status_t status;

  scfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  scfp_datapath #(
    .ZERO_RUN_MAX (ZERO_RUN_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ sv/scfp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_ctrl
// Sequencer: takes a byte, then steps through close and release results.
// ----------------------------------------------------------------------------
module scfp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  scfp_pkg::status_t status_i,
  output scfp_pkg::cmd_t    cmd_o
);
  import scfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCLOSE = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_RUN    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_sel = EMIT_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.is_zero) begin
            if (status_i.run_full) state_d = ST_CHECK;
          end else if (status_i.start_code) begin
            state_d = ST_SCLOSE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_SCLOSE: begin
        // an empty packet is skipped without a marker
        if (status_i.fill_zero) begin
          cmd_o.new_frame = 1'b1;
          state_d         = ST_CHECK;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_CLOSE;
          cmd_o.finish    = 1'b1;
          cmd_o.new_frame = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.over_limit && !status_i.fill_zero) begin
          if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_CLOSE;
            cmd_o.last     = status_i.held_zero && !status_i.extra;
            state_d        = ST_RUN;
          end
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.held_zero) begin
          if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_ZERO;
            cmd_o.last     = status_i.held_one && !status_i.extra;
            if (status_i.held_one && !status_i.extra) state_d = ST_IDLE;
          end
        end else if (status_i.extra) begin
          if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_BYTE;
            cmd_o.last     = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ sv/scfp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_datapath
// Zero run, fill, frame and packet counters, limit register, output register.
// ----------------------------------------------------------------------------
`include "start_code_frame_packetizer_defines.svh"

module scfp_datapath #(
  parameter int unsigned ZERO_RUN_MAX = scfp_pkg::ZERO_RUN_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scfp_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  logic [scfp_pkg::BYTE_W-1:0]      byte_i,
  input  scfp_pkg::cmd_t                   cmd_i,
  output scfp_pkg::status_t                status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [scfp_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                             out_kind_o,
  output logic                             out_last_o
);
  import scfp_pkg::*;

  logic [LEN_W-1:0]    limit_q;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [LEN_W-1:0]    fill_q, fill_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [PACKET_W-1:0] packet_q, packet_d;
  logic [BYTE_W-1:0]   byte_q;
  logic                extra_q;

  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic [FRAME_W-1:0]  out_frame_q;
  logic [PACKET_W-1:0] out_packet_q;
  logic                out_first_q;
  logic                out_finish_q;
  logic [LEN_W-1:0]    out_len_q;
  logic                out_last_q;

  logic [LEN_W:0]      release_sum;
  logic                out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign release_sum = {1'b0, fill_q} + (LEN_W+1)'(held_q) + (LEN_W+1)'(extra_q);

  always_comb begin
    status_o.is_zero    = (byte_i == '0);
    status_o.start_code = (held_q == START_ZEROS) && (byte_i == START_BYTE);
    status_o.run_full   = ({1'b0, held_q} + (HELD_W+1)'(1)) >= (HELD_W+1)'(ZERO_RUN_MAX);
    status_o.fill_zero  = (fill_q == '0);
    status_o.over_limit = release_sum > {1'b0, limit_q};
    status_o.held_zero  = (held_q == '0);
    status_o.held_one   = (held_q == HELD_W'(1));
    status_o.extra      = extra_q;
    status_o.out_free   = out_free;
  end

  always_comb begin
    held_d   = held_q;
    fill_d   = fill_q;
    packet_d = packet_q;
    frame_d  = frame_q;
    if (cmd_i.load && (byte_i == '0)) held_d = held_q + HELD_W'(1);
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        EMIT_CLOSE: begin
          fill_d   = '0;
          packet_d = packet_q + PACKET_W'(1);
        end
        EMIT_ZERO: begin
          held_d = held_q - HELD_W'(1);
          fill_d = fill_q + LEN_W'(1);
        end
        default: fill_d = fill_q + LEN_W'(1);
      endcase
    end
    if (cmd_i.new_frame) begin
      fill_d   = '0;
      packet_d = '0;
      frame_d  = (frame_q == FRAME_WRAP) ? '0 : frame_q + FRAME_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      held_q      <= '0;
      fill_q      <= '0;
      frame_q     <= FRAME_RESET;
      packet_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      held_q   <= held_d;
      fill_q   <= fill_d;
      frame_q  <= frame_d;
      packet_q <= packet_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q  <= byte_i;
      extra_q <= (byte_i != '0);
    end
    if (cmd_i.emit) begin
      out_kind_q   <= (cmd_i.emit_sel == EMIT_CLOSE) ? KIND_CLOSE : KIND_PAYLOAD;
      out_byte_q   <= (cmd_i.emit_sel == EMIT_BYTE) ? byte_q : '0;
      out_frame_q  <= frame_q;
      out_packet_q <= packet_q;
      out_first_q  <= (packet_q == '0);
      out_finish_q <= cmd_i.finish;
      out_len_q    <= (cmd_i.emit_sel == EMIT_CLOSE) ? fill_q : '0;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  // byte | frame | packet | first | finish | length | zero pad
  assign out_data_o  = {3'b000, out_len_q, out_finish_q, out_first_q,
                        out_packet_q, out_frame_q, out_byte_q};

  `SCFP_ASSERT_IMP(a_held_bound, clk_i, rst_ni, 1'b1, {1'b0, held_q} <= (HELD_W+1)'(ZERO_RUN_MAX))
  `SCFP_ASSERT_IMP(a_emit_has_room, clk_i, rst_ni, cmd_i.emit, out_free)
  `SCFP_ASSERT_IMP(a_no_empty_close, clk_i, rst_ni, out_valid_q && (out_kind_q == KIND_CLOSE), out_len_q != '0)
  `SCFP_ASSERT_IMP(a_payload_clean, clk_i, rst_ni, out_valid_q && (out_kind_q == KIND_PAYLOAD), !out_finish_q && (out_len_q == '0))
  `SCFP_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q && $stable(out_data_o))

endmodule

@@ tb/sv/scfp_packet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_packet_checker
// Watches both stream channels and the limit register port of the start code
// packetizer. Rebuilds the expected output transactions from every accepted
// input byte and compares them in order against what the block sends.
// ----------------------------------------------------------------------------
module scfp_packet_checker #(
  parameter int unsigned ZERO_RUN_MAX = scfp_pkg::ZERO_RUN_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scfp_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [scfp_pkg::BYTE_W-1:0]      s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [scfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               pending_o,
  output int                               mismatches_o,
  output int                               results_o,
  output int                               closes_o
);
  import scfp_pkg::*;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [2:0]          pad;
    logic [LEN_W-1:0]    packet_length;
    logic                frame_finish;
    logic                first_in_frame;
    logic [PACKET_W-1:0] packet_number;
    logic [FRAME_W-1:0]  frame_number;
    logic [BYTE_W-1:0]   payload_byte;
  } out_word_t;

  typedef struct {
    kind_e     kind;
    out_word_t word;
    logic      last_of_run;
  } out_item_t;

  out_item_t           expected_q[$];

  logic [LEN_W-1:0]    payload_limit;
  logic [HELD_W-1:0]   held_zeros;
  logic [LEN_W-1:0]    fill_count;
  logic [FRAME_W-1:0]  frame_num;
  logic [PACKET_W-1:0] packet_num;

  int                  mismatch_count;
  int                  results_seen;
  int                  closes_seen;

  function automatic void push_result(kind_e kind, logic [BYTE_W-1:0] data,
                                      logic finish, logic [LEN_W-1:0] len);
    out_item_t item;
    item.kind                = kind;
    item.last_of_run         = 1'b0;
    item.word                = '0;
    item.word.payload_byte   = data;
    item.word.frame_number   = frame_num;
    item.word.packet_number  = packet_num;
    item.word.first_in_frame = (packet_num == '0);
    item.word.frame_finish   = finish;
    item.word.packet_length  = len;
    expected_q.push_back(item);
  endfunction

  // empty packets are dropped silently
  function automatic void close_packet(logic finish);
    if (fill_count != '0) begin
      push_result(KIND_CLOSE, '0, finish, fill_count);
      packet_num = packet_num + 1'b1;
      fill_count = '0;
    end
  endfunction

  // held zeros go out first, then the byte itself when there is one
  function automatic void flush_held(logic with_byte, logic [BYTE_W-1:0] data);
    int total;
    total = int'(fill_count) + int'(held_zeros) + int'(with_byte);
    if (total > int'(payload_limit)) begin
      close_packet(1'b0);
      total = int'(held_zeros) + int'(with_byte);
    end
    for (int i = 0; i < int'(held_zeros); i++) begin
      push_result(KIND_PAYLOAD, '0, 1'b0, '0);
    end
    if (with_byte) begin
      push_result(KIND_PAYLOAD, data, 1'b0, '0);
    end
    fill_count = LEN_W'(total);
    held_zeros = '0;
  endfunction

  function automatic void packetize_byte(logic [BYTE_W-1:0] data);
    int before_count;
    before_count = expected_q.size();
    if (data == '0) begin
      held_zeros = held_zeros + 1'b1;
      if (int'(held_zeros) >= ZERO_RUN_MAX) begin
        flush_held(1'b0, '0);
      end
    end else begin
      if (held_zeros == START_ZEROS && data == START_BYTE) begin
        close_packet(1'b1);
        frame_num  = (frame_num == FRAME_WRAP) ? '0 : frame_num + 1'b1;
        packet_num = '0;
        fill_count = '0;
      end
      flush_held(1'b1, data);
    end
    if (expected_q.size() > before_count) begin
      expected_q[expected_q.size()-1].last_of_run = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic check_result();
    out_word_t got;
    out_item_t want;
    got = out_word_t'(m_axis_tdata);
    results_seen++;
    if (m_axis_tuser == KIND_CLOSE) begin
      closes_seen++;
    end
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    check_field("item_kind", m_axis_tuser, want.kind);
    check_field("payload_byte", got.payload_byte, want.word.payload_byte);
    check_field("frame_number", got.frame_number, want.word.frame_number);
    check_field("packet_number", got.packet_number, want.word.packet_number);
    check_field("first_in_frame", got.first_in_frame, want.word.first_in_frame);
    check_field("frame_finish", got.frame_finish, want.word.frame_finish);
    check_field("packet_length", got.packet_length, want.word.packet_length);
    check_field("tdata pad", got.pad, want.word.pad);
    check_field("last_of_run", m_axis_tlast, want.last_of_run);
  endtask

  // outputs go out through nonblocking updates so the stimulus side reads
  // last edge's values regardless of process order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      payload_limit  = LIMIT_RESET;
      held_zeros     = '0;
      fill_count     = '0;
      frame_num      = FRAME_RESET;
      packet_num     = '0;
      mismatch_count = 0;
      results_seen   = 0;
      closes_seen    = 0;
      pending_o     <= 0;
      mismatches_o  <= 0;
      results_o     <= 0;
      closes_o      <= 0;
    end else begin
      // results of this edge's input byte can only come later
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (cfg_we_i) begin
        payload_limit = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        packetize_byte(s_axis_tdata);
      end
      pending_o    <= expected_q.size();
      mismatches_o <= mismatch_count;
      results_o    <= results_seen;
      closes_o     <= closes_seen;
    end
  end

endmodule

@@ tb/sv/start_code_frame_packetizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_code_frame_packetizer_test
// Drives byte streams with start codes, zero runs and near misses into the
// packetizer under several payload limits, stalls both channels at random,
// and takes the verdict from the packet checker.
// ----------------------------------------------------------------------------
module start_code_frame_packetizer_test;
  import scfp_pkg::*;

  localparam int unsigned ZERO_RUN_MAX  = ZERO_RUN_MAX_DEF;
  localparam int          IDLE_PCT      = 21;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          END_CYCLES    = 16;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          NO_IDLE_BYTES = 60;  // stretch with both sides always ready

  localparam logic [BYTE_W-1:0] DIRECTED_BYTES [24] = '{
    8'h00, 8'h00, 8'h00, 8'h01,          // start code on an empty packet
    8'hFF, 8'h80, 8'h7F, 8'h01,          // 01 with nothing held
    8'h00, 8'h01,                        // one zero
    8'h00, 8'h00, 8'h01,                 // two zeros
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01,   // four zeros, no start code
    8'h00, 8'h00, 8'h00, 8'h01,          // start code closing a packet
    8'hAA, 8'h55
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  int pending;
  int mismatches;
  int results;
  int closes;
  int bytes_sent   = 0;
  int stall_cycles = 0;
  bit idle_on      = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  start_code_frame_packetizer #(
    .ZERO_RUN_MAX(ZERO_RUN_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  scfp_packet_checker #(
    .ZERO_RUN_MAX(ZERO_RUN_MAX)
  ) packet_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .results_o    (results),
    .closes_o     (closes)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // run ends if no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results pending",
               STALL_LIMIT, pending);
      $display("start_code_frame_packetizer_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // tvalid stays high across back-to-back bytes; lowered only for gaps
  task automatic send_byte(input logic [BYTE_W-1:0] data);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_start_code();
    repeat (3) send_byte(8'h00);
    send_byte(START_BYTE);
  endtask

  task automatic send_segment();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      len = $urandom_range(1, 12);
      repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      send_start_code();
    end else if (pick < 80) begin
      // short runs, or runs around the release bound
      len = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 6)
                                        : $urandom_range(ZERO_RUN_MAX - 4, ZERO_RUN_MAX + 8);
      repeat (len) send_byte(8'h00);
      send_byte(BYTE_W'($urandom_range(1, 255)));
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0: begin
          repeat (3) send_byte(8'h00);
          send_byte(BYTE_W'($urandom_range(2, 255)));
        end
        1: begin
          repeat (2) send_byte(8'h00);
          send_byte(START_BYTE);
        end
        default: begin
          repeat (4 + $urandom_range(0, 2)) send_byte(8'h00);
          send_byte(START_BYTE);
        end
      endcase
    end else begin
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_stream(input int n_items);
    int stop_at;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) send_segment();
  endtask

  task automatic wait_drained(input int tail_cycles);
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail_cycles) @(posedge clk_i);
  endtask

  task automatic write_payload_limit(input logic [LEN_W-1:0] value);
    wait_drained(DRAIN_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit
    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    random_stream(40);

    // limit below the zero run bound: zero runs overflow packets
    write_payload_limit(LEN_W'(16));
    random_stream(90);

    // zero limit, every byte closes the previous packet; no idling on either side
    write_payload_limit('0);
    idle_on = 1'b0;
    repeat (NO_IDLE_BYTES) send_byte(BYTE_W'($urandom_range(1, 255)));
    idle_on = 1'b1;

    write_payload_limit(LEN_W'(1472));
    random_stream(90);

    write_payload_limit('1);
    random_stream(40);

    write_payload_limit(LEN_W'(40));
    random_stream(50);

    wait_drained(END_CYCLES);

    $display("sent %0d stream bytes under payload limits 1400, 16, 0, 1472, 2047, 40",
             bytes_sent);
    $display("checked %0d results, %0d packet closes, with a stretch of unbroken traffic",
             results, closes);
    if (mismatches == 0 && pending == 0) begin
      $display("start_code_frame_packetizer_test OK");
    end else begin
      $display("%0d mismatches, %0d expected results missing", mismatches, pending);
      $display("start_code_frame_packetizer_test NOT OK");
    end
    $finish;
  end

endmodule
